[rtl/pipo_pkg.sv]
// Package with the block type, codes and round functions of the 64-bit cipher.
package pipo_pkg;

    // A block is eight byte rows; row k is bits 8k+7..8k.
    typedef logic [7:0][7:0] t_blk;

    localparam int unsigned N_STAGES   = 15;
    localparam int unsigned ROUNDS_128 = 13;
    localparam int unsigned ROUNDS_256 = 15;

    // Configuration register indexes.
    localparam logic [2:0] CFG_KEY_LEN = 3'd0;
    localparam logic [2:0] CFG_KEY_W0  = 3'd1;
    localparam logic [2:0] CFG_KEY_W1  = 3'd2;
    localparam logic [2:0] CFG_KEY_W2  = 3'd3;
    localparam logic [2:0] CFG_KEY_W3  = 3'd4;

    // Request codes.
    localparam logic REQ_ENC = 1'b0;
    localparam logic REQ_DEC = 1'b1;

    function automatic logic [7:0] f_rotl(input logic [7:0] v, input int unsigned s);
        return 8'((v << s) | (v >> (8 - s)));
    endfunction

    // Bitsliced forward S-box across the eight rows.
    function automatic t_blk f_fwd_sub(input t_blk xi);
        t_blk       x;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic [7:0] s;
        x = xi;
        x[5] = x[5] ^ (x[7] & x[6]);
        x[4] = x[4] ^ (x[3] & x[5]);
        x[7] = x[7] ^ x[4];
        x[6] = x[6] ^ x[3];
        x[3] = x[3] ^ (x[4] | x[5]);
        x[5] = x[5] ^ x[7];
        x[4] = x[4] ^ (x[5] & x[6]);
        x[2] = x[2] ^ (x[1] & x[0]);
        x[0] = x[0] ^ (x[2] | x[1]);
        x[1] = x[1] ^ (x[2] | x[0]);
        x[2] = ~x[2];
        x[7] = x[7] ^ x[1];
        x[3] = x[3] ^ x[2];
        x[4] = x[4] ^ x[0];
        a = x[7];
        b = x[3];
        c = x[4];
        x[6] = x[6] ^ (a & x[5]);
        a = a ^ x[6];
        x[6] = x[6] ^ (c | b);
        b = b ^ x[5];
        x[5] = x[5] ^ (x[6] | c);
        c = c ^ (b & a);
        x[2] = x[2] ^ a;
        a = x[1] ^ c;
        x[1] = x[0] ^ b;
        x[0] = x[7];
        x[7] = a;
        s = x[3];
        x[3] = x[6];
        x[6] = s;
        s = x[4];
        x[4] = x[5];
        x[5] = s;
        return x;
    endfunction

    // Bitsliced inverse S-box.
    function automatic t_blk f_inv_sub(input t_blk xi);
        t_blk       x;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        x = xi;
        a = x[7];
        x[7] = x[0];
        x[0] = x[1];
        x[1] = a;
        a = x[7];
        b = x[6];
        c = x[5];
        x[4] = x[4] ^ (x[3] | c);
        x[3] = x[3] ^ (c | b);
        b = b ^ x[4];
        a = a ^ x[3];
        c = c ^ (b & a);
        x[3] = x[3] ^ (x[4] & x[7]);
        x[0] = x[0] ^ b;
        x[1] = x[1] ^ c;
        x[2] = x[2] ^ a;
        a = x[3];
        x[3] = x[6];
        x[6] = a;
        a = x[5];
        x[5] = x[4];
        x[4] = a;
        x[7] = x[7] ^ x[1];
        x[3] = x[3] ^ x[2];
        x[4] = x[4] ^ x[0];
        x[4] = x[4] ^ (x[5] & x[6]);
        x[5] = x[5] ^ x[7];
        x[3] = x[3] ^ (x[4] | x[5]);
        x[6] = x[6] ^ x[3];
        x[7] = x[7] ^ x[4];
        x[4] = x[4] ^ (x[3] & x[5]);
        x[5] = x[5] ^ (x[7] & x[6]);
        x[2] = ~x[2];
        x[1] = x[1] ^ (x[2] | x[0]);
        x[0] = x[0] ^ (x[2] | x[1]);
        x[2] = x[2] ^ (x[1] & x[0]);
        return x;
    endfunction

    // Fixed row rotations.
    function automatic t_blk f_fwd_perm(input t_blk xi);
        t_blk x;
        x = xi;
        x[1] = f_rotl(x[1], 7);
        x[2] = f_rotl(x[2], 4);
        x[3] = f_rotl(x[3], 3);
        x[4] = f_rotl(x[4], 6);
        x[5] = f_rotl(x[5], 5);
        x[6] = f_rotl(x[6], 1);
        x[7] = f_rotl(x[7], 2);
        return x;
    endfunction

    function automatic t_blk f_inv_perm(input t_blk xi);
        t_blk x;
        x = xi;
        x[1] = f_rotl(x[1], 1);
        x[2] = f_rotl(x[2], 4);
        x[3] = f_rotl(x[3], 5);
        x[4] = f_rotl(x[4], 2);
        x[5] = f_rotl(x[5], 3);
        x[6] = f_rotl(x[6], 7);
        x[7] = f_rotl(x[7], 6);
        return x;
    endfunction

endpackage

[rtl/pipo_if.sv]
// Valid/ready channel interfaces for the request and response words.
interface pipo_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [63:0] data_in;

    modport source (output valid, output req_type, output data_in, input ready);
    modport sink   (input valid, input req_type, input data_in, output ready);
endinterface

interface pipo_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface

[rtl/pipo64_block_cipher_unit.sv]
// Top level: fully pipelined 64-bit block cipher, one round per stage.
//
// Usage: write the key length and the key words on the configuration port
// while the unit is idle; index 0 is the key length (0: 128-bit key and
// 13 rounds, 1: 256-bit key and 15 rounds), indexes 1..4 are key words 0..3.
// Writes to other indexes are ignored.
// Each word on the request channel carries req_type (0 encrypt, 1 decrypt)
// and a 64-bit block; each produces exactly one word on the response channel,
// in order.
// A result word passes through all 15 round stages for both key lengths;
// with the 128-bit key the last two stages do no round, though the last
// still adds the whitening key on decryption. Throughput is one word per
// cycle while the receiver is ready.
// Every stage has its own valid bit and loads when it is empty or when the
// stage after it moves, so bubbles close up while the receiver stalls and the
// unit keeps taking requests until all 15 stages hold words.
// Reset empties the pipeline and clears all configuration registers to zero.
module pipo64_block_cipher_unit
    import pipo_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [63:0]   i_cfg_wdata,
    pipo_req_if.sink      i_req,
    pipo_rsp_if.source    o_rsp
);

    // Configuration registers.
    logic              r_key_len;
    logic [3:0][63:0]  r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len <= 1'b0;
            r_key     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_LEN: r_key_len <= i_cfg_wdata[0];
                CFG_KEY_W0:  r_key[0]  <= i_cfg_wdata;
                CFG_KEY_W1:  r_key[1]  <= i_cfg_wdata;
                CFG_KEY_W2:  r_key[2]  <= i_cfg_wdata;
                CFG_KEY_W3:  r_key[3]  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Round count and the index sum used to number decryption rounds.
    logic [3:0] w_rounds;
    logic [4:0] w_dec_base;

    assign w_rounds   = r_key_len ? 4'(ROUNDS_256) : 4'(ROUNDS_128);
    assign w_dec_base = 5'(w_rounds) + 5'd1;

    // Pipeline registers, one slot per round stage.
    logic [N_STAGES:1]  r_vld;
    logic [N_STAGES:1]  r_dec;
    t_blk               r_dat [N_STAGES:1];
    logic [N_STAGES+1:1] w_load;

    assign w_load[N_STAGES+1] = o_rsp.ready;

    genvar j;
    generate
        for (j = 1; j <= N_STAGES; j++) begin : g_stage
            localparam logic [3:0] STG = 4'(j);

            logic        w_vin;
            logic        w_din_dec;
            t_blk        w_din;
            logic        w_active;
            logic [3:0]  w_ki;
            logic [1:0]  w_ksel;
            logic [63:0] w_rk;
            t_blk        w_enc;
            t_blk        w_dcr;
            t_blk        n_dat;

            // Inputs from the port or the previous stage.
            if (j == 1) begin : g_first
                assign w_vin     = i_req.valid;
                assign w_din_dec = i_req.req_type;
                assign w_din     = t_blk'(i_req.data_in);
            end else begin : g_mid
                assign w_vin     = r_vld[j-1];
                assign w_din_dec = r_dec[j-1];
                assign w_din     = r_dat[j-1];
            end

            // A stage loads when empty or when its word moves on.
            assign w_load[j] = !r_vld[j] || w_load[j+1];

            // Round number and round key for this stage.
            assign w_active = (STG <= w_rounds);
            assign w_ki     = (w_din_dec == REQ_DEC) ? 4'(w_dec_base - 5'(STG)) : STG;
            assign w_ksel   = r_key_len ? w_ki[1:0] : {1'b0, w_ki[0]};
            assign w_rk     = r_key[w_ksel] ^ {60'd0, w_ki};

            always_comb begin
                t_blk x;
                // Encryption: whitening key on entry, then S-box, rotate, key.
                x = w_din;
                if (j == 1) begin
                    x = x ^ t_blk'(r_key[0]);
                end
                w_enc = f_fwd_perm(f_fwd_sub(x)) ^ t_blk'(w_rk);
                // Decryption: key, inverse rotate, inverse S-box.
                w_dcr = f_inv_sub(f_inv_perm(w_din ^ t_blk'(w_rk)));

                if (!w_active) begin
                    n_dat = w_din;
                end else if (w_din_dec == REQ_DEC) begin
                    n_dat = w_dcr;
                end else begin
                    n_dat = w_enc;
                end
                // Decryption ends with the whitening key.
                if (j == N_STAGES && w_din_dec == REQ_DEC) begin
                    n_dat = n_dat ^ t_blk'(r_key[0]);
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[j] <= 1'b0;
                end else if (w_load[j]) begin
                    r_vld[j] <= w_vin;
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_load[j]) begin
                    r_dec[j] <= w_din_dec;
                    r_dat[j] <= n_dat;
                end
            end
        end
    endgenerate

    assign i_req.ready    = w_load[1];
    assign o_rsp.valid    = r_vld[N_STAGES];
    assign o_rsp.data_out = 64'(r_dat[N_STAGES]);

endmodule

[sim/pipo64_block_cipher_unit_tb.sv]
// Self-checking testbench for the pipelined 64-bit block cipher unit.
module pipo64_block_cipher_unit_tb
    import pipo_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_STALL_CYCLES = 80;

    // Left rotation applied to each row by the forward permutation.
    localparam int unsigned ROW_SHIFT [8] = '{0, 7, 4, 3, 6, 5, 1, 2};

    // Expected-result store with its own copy of the key registers.
    class cipher_scoreboard;
        logic        wide_key;
        logic [63:0] key_words [4];
        logic [63:0] expected_q [$];
        int          n_errors;

        function new();
            wide_key = 1'b0;
            foreach (key_words[k]) key_words[k] = '0;
            n_errors = 0;
        endfunction

        // Mirror one configuration write; out-of-range indexes change nothing.
        function void set_reg(logic [2:0] idx, logic [63:0] value);
            if (idx == CFG_KEY_LEN) begin
                wide_key = value[0];
            end else if (idx >= CFG_KEY_W0 && idx <= CFG_KEY_W3) begin
                key_words[idx - CFG_KEY_W0] = value;
            end
        endfunction

        function logic [63:0] subkey(int unsigned i);
            int unsigned n_words;
            n_words = wide_key ? 4 : 2;
            return key_words[i % n_words] ^ 64'(i);
        endfunction

        function logic [7:0] rol8(logic [7:0] v, int unsigned s);
            logic [15:0] w;
            w = {v, v} << s;
            return w[15:8];
        endfunction

        function t_blk rotate_rows(t_blk x, bit undo);
            t_blk y;
            y = x;
            for (int k = 1; k < 8; k++) begin
                y[k] = rol8(x[k], undo ? (8 - ROW_SHIFT[k]) : ROW_SHIFT[k]);
            end
            return y;
        endfunction

        // Forward bitsliced S-box, applied to all eight columns at once.
        function t_blk sbox_fwd(t_blk xi);
            t_blk       x;
            logic [7:0] a;
            logic [7:0] b;
            logic [7:0] c;
            x = xi;
            x[5] ^= x[7] & x[6];
            x[4] ^= x[3] & x[5];
            x[7] ^= x[4];
            x[6] ^= x[3];
            x[3] ^= x[4] | x[5];
            x[5] ^= x[7];
            x[4] ^= x[5] & x[6];
            x[2] ^= x[1] & x[0];
            x[0] ^= x[2] | x[1];
            x[1] ^= x[2] | x[0];
            x[2] = ~x[2];
            x[7] ^= x[1];
            x[3] ^= x[2];
            x[4] ^= x[0];
            a = x[7];
            b = x[3];
            c = x[4];
            x[6] ^= a & x[5];
            a ^= x[6];
            x[6] ^= c | b;
            b ^= x[5];
            x[5] ^= x[6] | c;
            c ^= b & a;
            x[2] ^= a;
            a = x[1] ^ c;
            x[1] = x[0] ^ b;
            x[0] = x[7];
            x[7] = a;
            {x[3], x[6]} = {x[6], x[3]};
            {x[4], x[5]} = {x[5], x[4]};
            return x;
        endfunction

        // Inverse bitsliced S-box.
        function t_blk sbox_inv(t_blk xi);
            t_blk       x;
            logic [7:0] a;
            logic [7:0] b;
            logic [7:0] c;
            x = xi;
            a = x[7];
            x[7] = x[0];
            x[0] = x[1];
            x[1] = a;
            a = x[7];
            b = x[6];
            c = x[5];
            x[4] ^= x[3] | c;
            x[3] ^= c | b;
            b ^= x[4];
            a ^= x[3];
            c ^= b & a;
            x[3] ^= x[4] & x[7];
            x[0] ^= b;
            x[1] ^= c;
            x[2] ^= a;
            {x[3], x[6]} = {x[6], x[3]};
            {x[4], x[5]} = {x[5], x[4]};
            x[7] ^= x[1];
            x[3] ^= x[2];
            x[4] ^= x[0];
            x[4] ^= x[5] & x[6];
            x[5] ^= x[7];
            x[3] ^= x[4] | x[5];
            x[6] ^= x[3];
            x[7] ^= x[4];
            x[4] ^= x[3] & x[5];
            x[5] ^= x[7] & x[6];
            x[2] = ~x[2];
            x[1] ^= x[2] | x[0];
            x[0] ^= x[2] | x[1];
            x[2] ^= x[1] & x[0];
            return x;
        endfunction

        // Compute the result block for one accepted request word.
        function logic [63:0] cipher_block(logic op, logic [63:0] blk);
            t_blk        x;
            int unsigned n_rounds;
            n_rounds = wide_key ? ROUNDS_256 : ROUNDS_128;
            x = blk;
            if (op == REQ_ENC) begin
                x = x ^ subkey(0);
                for (int unsigned i = 1; i <= n_rounds; i++) begin
                    x = rotate_rows(sbox_fwd(x), 1'b0);
                    x = x ^ subkey(i);
                end
            end else begin
                for (int unsigned i = n_rounds; i > 0; i--) begin
                    x = x ^ subkey(i);
                    x = sbox_inv(rotate_rows(x, 1'b1));
                end
                x = x ^ subkey(0);
            end
            return x;
        endfunction

        function void note_request(logic op, logic [63:0] blk);
            expected_q.push_back(cipher_block(op, blk));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task flag_mismatch(string what);
            n_errors++;
            $display("[%0t] mismatch %0d: %s", $realtime, n_errors, what);
        endtask

        task check_response(logic [63:0] got);
            logic [63:0] want;
            if (expected_q.size() == 0) begin
                flag_mismatch($sformatf("result word %h with nothing expected", got));
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    flag_mismatch($sformatf("data_out %h, expected %h", got, want));
                end
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_wdata;

    pipo_req_if req_ch ();
    pipo_rsp_if rsp_ch ();

    pipo64_block_cipher_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    cipher_scoreboard sb = new();

    int src_gap_pct;
    int snk_stall_pct;
    bit long_stall_req;
    int cycle_count;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Response ready: random stalls, plus one long hold-off on request.
    initial begin
        int hold;
        hold = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                hold = LONG_STALL_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    // Check each accepted result word.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            sb.check_response(rsp_ch.data_out);
        end
    end

    // Offer one request word, with random gaps before it, until accepted.
    task automatic push_block(input logic op, input logic [63:0] blk);
        while ($urandom_range(99) < src_gap_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= op;
        req_ch.data_in  <= blk;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(op, blk);
    endtask

    // Mostly dense random blocks, sometimes extremes and single-bit patterns.
    function automatic logic [63:0] rand_block();
        logic [63:0] one_hot;
        one_hot = 64'd1 << $urandom_range(63);
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            2:       return one_hot;
            3:       return ~one_hot;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic run_traffic(input int n_words);
        logic op;
        for (int k = 0; k < n_words; k++) begin
            op = ($urandom_range(1) == 0) ? REQ_ENC : REQ_DEC;
            push_block(op, rand_block());
        end
    endtask

    // Encrypt and decrypt the same block.
    task automatic push_both(input logic [63:0] blk);
        push_block(REQ_ENC, blk);
        push_block(REQ_DEC, blk);
    endtask

    // Stop offering words and wait until every expected result is back.
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.set_reg(idx, value);
    endtask

    // Load all registers, then one write to an unused index.
    task automatic load_key(input logic [63:0] len_word, input logic [63:0] w0,
                            input logic [63:0] w1, input logic [63:0] w2,
                            input logic [63:0] w3);
        cfg_write(CFG_KEY_LEN, len_word);
        cfg_write(CFG_KEY_W0, w0);
        cfg_write(CFG_KEY_W1, w1);
        cfg_write(CFG_KEY_W2, w2);
        cfg_write(CFG_KEY_W3, w3);
        cfg_write(3'(CFG_KEY_W3 + $urandom_range(1, 3)), {$urandom, $urandom});
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_KEY_LEN;
        i_cfg_wdata     = '0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_ENC;
        req_ch.data_in  = '0;
        long_stall_req  = 1'b0;
        src_gap_pct     = 16;
        snk_stall_pct   = 73;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset key: all zero, short key.
        push_both('0);
        push_both('1);
        push_both(64'h0123_4567_89AB_CDEF);
        run_traffic(150);
        drain();

        // Only the low bit of the key length word counts; all-ones key.
        load_key(64'hFFFF_FFFF_FFFF_FFFE, '1, '1, '1, '1);
        push_both('0);
        push_both('1);
        run_traffic(150);
        drain();

        // Long key from a wide length word; the receiver holds off for a while.
        load_key(64'h8000_0000_0000_0001, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
        long_stall_req = 1'b1;
        run_traffic(180);
        drain();

        src_gap_pct   = 73;
        snk_stall_pct = 16;

        // Long key with alternating extreme words.
        load_key(64'd1, '1, '0, '1, '0);
        push_both('0);
        push_both('1);
        push_both(64'h8000_0000_0000_0001);
        run_traffic(150);
        drain();

        load_key(64'd0, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
        run_traffic(150);
        drain();

        src_gap_pct   = 0;
        snk_stall_pct = 0;

        load_key(64'd1, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
        long_stall_req = 1'b1;
        run_traffic(160);
        drain();

        load_key(64'd0, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
        run_traffic(160);
        drain();

        if (sb.n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
